### rtl/core/adam_parameter_update_assert.svh
// Assertion macros shared by the Adam update block.
`ifndef ADAM_PARAMETER_UPDATE_ASSERT_SVH
`define ADAM_PARAMETER_UPDATE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define APU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/apu_pkg.sv
// Shared constants and types for the Adam parameter update block.
`timescale 1ns / 1ps

package apu_pkg;

    // Store geometry; the slot is the low index bits, so the count is a power of two.
    localparam int PARAM_COUNT = 4096;
    localparam int ADDR_W      = $clog2(PARAM_COUNT);
    localparam int IDX_W       = 12;
    localparam int DATA_W      = 32;
    localparam int CACHE_W     = 48;
    localparam int EPS_W       = 31;

    // Square root and divider pipeline shape.
    localparam int SQRT_STAGES = 16;
    localparam int SQRT_STEPS  = 2;
    localparam int DIV_STAGES  = 32;
    localparam int DIV_STEPS   = 2;

    // Configuration register reset values.
    localparam logic [31:0] STEP_SIZE_RST = 32'd4294967;
    localparam logic [31:0] BETA_ONE_RST  = 32'd3865470566;
    localparam logic [31:0] BETA_TWO_RST  = 32'd4290672329;
    localparam logic [31:0] MOM_CORR_RST  = 32'd655360;
    localparam logic [31:0] CACHE_CORR_RST = 32'd65536000;
    localparam logic [30:0] EPSILON_RST   = 31'd2;

    // Saturation limits of Q8.24 in a 34-bit working width.
    localparam logic signed [33:0] Q824_MAX = 34'sd2147483647;
    localparam logic signed [33:0] Q824_MIN = -34'sd2147483648;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_STEP_SIZE  = 3'd0,
        REG_BETA_ONE   = 3'd1,
        REG_BETA_TWO   = 3'd2,
        REG_MOM_CORR   = 3'd3,
        REG_CACHE_CORR = 3'd4,
        REG_EPSILON    = 3'd5
    } apu_reg_t;

    // Live configuration seen by the datapath.
    typedef struct packed {
        logic [31:0]      step_size;
        logic [31:0]      beta_one;
        logic [31:0]      beta_two;
        logic [31:0]      momentum_correction;
        logic [31:0]      cache_correction;
        logic [EPS_W-1:0] epsilon;
    } apu_cfg_t;

    // Per-word fields that ride along with the math.
    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] weight;
    } apu_side_t;

    // Fields carried through the square root toward the divider.
    typedef struct packed {
        apu_side_t   side;
        logic        mneg;
        logic        sat;
        logic [63:0] num;
    } apu_carry_t;

endpackage

### rtl/core/apu_in_if.sv
// Input channel: one parameter update word per handshake.
`timescale 1ns / 1ps

interface apu_in_if import apu_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         param_index;
    logic signed [DATA_W-1:0] weight;
    logic signed [DATA_W-1:0] gradient;

    modport source (output valid, param_index, weight, gradient, input ready);
    modport sink   (input valid, param_index, weight, gradient, output ready);
endinterface

### rtl/core/apu_out_if.sv
// Output channel: one updated weight word per handshake.
`timescale 1ns / 1ps

interface apu_out_if import apu_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         param_index_out;
    logic signed [DATA_W-1:0] new_weight;
    logic                     saturated;

    modport source (output valid, param_index_out, new_weight, saturated, input ready);
    modport sink   (input valid, param_index_out, new_weight, saturated, output ready);
endinterface

### rtl/core/apu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module apu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/apu_moment.sv
// Moment stores and the first and second moment update.
`timescale 1ns / 1ps

module apu_moment import apu_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  apu_cfg_t                  cfg,
    input  logic                      acc,
    input  logic [IDX_W-1:0]          acc_idx,
    input  logic signed [DATA_W-1:0]  acc_weight,
    input  logic signed [DATA_W-1:0]  acc_gradient,
    output logic                      clear_done,
    output logic                      hazard,
    output logic                      out_valid,
    output apu_side_t                 out_side,
    output logic signed [DATA_W-1:0]  out_m,
    output logic [CACHE_W-1:0]        out_c
);

    logic [ADDR_W:0]          clr_cnt_reg, clr_cnt_next;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [DATA_W-1:0]        m_wdata, m_rdata;
    logic [CACHE_W-1:0]       c_wdata, c_rdata;

    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                     s5_valid_reg;
    apu_side_t                s1_side_reg, s2_side_reg, s3_side_reg, s4_side_reg, s5_side_reg;
    logic signed [DATA_W-1:0] s1_g_reg;

    logic signed [DATA_W-1:0] m_rd;
    logic [32:0]              nb1, nb2;
    logic signed [64:0]       pm1;
    logic signed [65:0]       pm2;
    logic [31:0]              gm;
    logic [63:0]              gg;
    logic [47:0]              cb_hi;
    logic [63:0]              cb_lo;
    logic signed [64:0]       s2_pm1_reg;
    logic signed [65:0]       s2_pm2_reg;
    logic [63:0]              s2_gg_reg;
    logic [47:0]              s2_cb_hi_reg, s3_cb_hi_reg, s4_cb_hi_reg;
    logic [63:0]              s2_cb_lo_reg, s3_cb_lo_reg, s4_cb_lo_reg;

    logic signed [66:0]       psum;
    logic [66:0]              pmag, rsum;
    logic [31:0]              rmag, mnew;
    logic [63:0]              ggr;
    logic [46:0]              gsq;
    logic [31:0]              s3_m_reg, s4_m_reg;
    logic [46:0]              s3_gsq_reg;

    logic [47:0]              gn_hi;
    logic [64:0]              gn_lo;
    logic [47:0]              s4_gn_hi_reg;
    logic [64:0]              s4_gn_lo_reg;

    logic [48:0]              hisum;
    logic [80:0]              total;
    logic [CACHE_W-1:0]       cnew;
    logic signed [DATA_W-1:0] s5_m_reg;
    logic [CACHE_W-1:0]       s5_c_reg;

    // Clearing pass over both stores after reset.
    assign clear_done   = clr_cnt_reg[ADDR_W];
    assign clr_cnt_next = clear_done ? clr_cnt_reg : clr_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Store write port: zeros during the clear, else the updated moments.
    assign ram_we    = !clear_done || (s4_valid_reg && adv);
    assign ram_waddr = clear_done ? s4_side_reg.idx[ADDR_W-1:0] : clr_cnt_reg[ADDR_W-1:0];
    assign m_wdata   = clear_done ? s4_m_reg : '0;
    assign c_wdata   = clear_done ? cnew : '0;

    apu_ram #(.WIDTH(DATA_W), .DEPTH(PARAM_COUNT)) u_mom_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (m_wdata),
        .re    (adv),
        .raddr (acc_idx[ADDR_W-1:0]),
        .rdata (m_rdata)
    );

    apu_ram #(.WIDTH(CACHE_W), .DEPTH(PARAM_COUNT)) u_cache_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (c_wdata),
        .re    (adv),
        .raddr (acc_idx[ADDR_W-1:0]),
        .rdata (c_rdata)
    );

    // A word whose slot is still being updated in flight must wait.
    assign hazard =
        (s1_valid_reg && (s1_side_reg.idx[ADDR_W-1:0] == acc_idx[ADDR_W-1:0])) ||
        (s2_valid_reg && (s2_side_reg.idx[ADDR_W-1:0] == acc_idx[ADDR_W-1:0])) ||
        (s3_valid_reg && (s3_side_reg.idx[ADDR_W-1:0] == acc_idx[ADDR_W-1:0])) ||
        (s4_valid_reg && (s4_side_reg.idx[ADDR_W-1:0] == acc_idx[ADDR_W-1:0]));

    // Stage 1: decay products of both moments and the gradient square.
    assign m_rd  = $signed(m_rdata);
    assign nb1   = 33'h1_0000_0000 - {1'b0, cfg.beta_one};
    assign pm1   = m_rd * $signed({1'b0, cfg.beta_one});
    assign pm2   = s1_g_reg * $signed({1'b0, nb1});
    assign gm    = s1_g_reg[31] ? (~s1_g_reg + 32'd1) : s1_g_reg;
    assign gg    = {32'd0, gm} * {32'd0, gm};
    assign cb_hi = c_rdata[47:32] * cfg.beta_two;
    assign cb_lo = {32'd0, c_rdata[31:0]} * {32'd0, cfg.beta_two};

    // Stage 2: round the first moment and the gradient square.
    assign psum = 67'(s2_pm1_reg) + 67'(s2_pm2_reg);
    assign pmag = psum[66] ? 67'(-psum) : 67'(psum);
    assign rsum = pmag + 67'd2147483648;
    assign rmag = rsum[63:32];
    assign mnew = psum[66] ? (~rmag + 32'd1) : rmag;
    assign ggr  = s2_gg_reg + 64'd32768;
    assign gsq  = ggr[62:16];

    // Stage 3: gradient square times one minus beta_two.
    assign nb2   = 33'h1_0000_0000 - {1'b0, cfg.beta_two};
    assign gn_hi = s3_gsq_reg[46:32] * nb2;
    assign gn_lo = {33'd0, s3_gsq_reg[31:0]} * {32'd0, nb2};

    // Stage 4: sum the cache terms and round to Q16.32.
    assign hisum = {1'b0, s4_cb_hi_reg} + {1'b0, s4_gn_hi_reg};
    assign total = {hisum, 32'd0} + 81'(s4_cb_lo_reg) + 81'(s4_gn_lo_reg)
                   + 81'd2147483648;
    assign cnew  = total[79:32];

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= acc;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_side_reg.idx    <= acc_idx;
            s1_side_reg.weight <= acc_weight;
            s1_g_reg           <= acc_gradient;
            s2_side_reg        <= s1_side_reg;
            s2_pm1_reg         <= pm1;
            s2_pm2_reg         <= pm2;
            s2_gg_reg          <= gg;
            s2_cb_hi_reg       <= cb_hi;
            s2_cb_lo_reg       <= cb_lo;
            s3_side_reg        <= s2_side_reg;
            s3_m_reg           <= mnew;
            s3_gsq_reg         <= gsq;
            s3_cb_hi_reg       <= s2_cb_hi_reg;
            s3_cb_lo_reg       <= s2_cb_lo_reg;
            s4_side_reg        <= s3_side_reg;
            s4_m_reg           <= s3_m_reg;
            s4_cb_hi_reg       <= s3_cb_hi_reg;
            s4_cb_lo_reg       <= s3_cb_lo_reg;
            s4_gn_hi_reg       <= gn_hi;
            s4_gn_lo_reg       <= gn_lo;
            s5_side_reg        <= s4_side_reg;
            s5_m_reg           <= $signed(s4_m_reg);
            s5_c_reg           <= cnew;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_side  = s5_side_reg;
    assign out_m     = s5_m_reg;
    assign out_c     = s5_c_reg;

endmodule

### rtl/core/apu_scale.sv
// Bias corrections and the numerator product, three stages.
`timescale 1ns / 1ps

module apu_scale import apu_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  apu_cfg_t                 cfg,
    input  logic                     in_valid,
    input  apu_side_t                in_side,
    input  logic signed [DATA_W-1:0] in_m,
    input  logic [CACHE_W-1:0]       in_c,
    output logic                     out_valid,
    output apu_carry_t               out_carry,
    output logic [63:0]              out_ch
);

    logic [31:0] mbits, mabs;
    logic [63:0] mp, chl;
    logic [47:0] chh;
    logic        a_valid_reg, b_valid_reg, c_valid_reg;
    apu_side_t   a_side_reg, b_side_reg;
    logic        a_mneg_reg, b_mneg_reg;
    logic [63:0] a_mp_reg, a_chl_reg;
    logic [47:0] a_chh_reg;

    logic [63:0] mr;
    logic [47:0] mh_full, mcap;
    logic [31:0] mh;
    logic        mclip, chclip;
    logic [64:0] chsum;
    logic [63:0] ch;
    logic [31:0] b_mh_reg;
    logic [63:0] b_ch_reg;
    logic        b_sat_reg;

    logic [63:0] num;
    apu_carry_t  c_carry_reg;
    logic [63:0] c_ch_reg;

    // Stage A: correction products.
    assign mbits = in_m;
    assign mabs  = mbits[31] ? (~mbits + 32'd1) : mbits;
    assign mp    = {32'd0, mabs} * {32'd0, cfg.momentum_correction};
    assign chh   = in_c[47:32] * cfg.cache_correction;
    assign chl   = {32'd0, in_c[31:0]} * {32'd0, cfg.cache_correction};

    // Stage B: round and clip the momentum, assemble and clip the cache.
    assign mr      = a_mp_reg + 64'd32768;
    assign mh_full = mr[63:16];
    assign mcap    = a_mneg_reg ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
    assign mclip   = mh_full > mcap;
    assign mh      = mclip ? mcap[31:0] : mh_full[31:0];
    assign chsum   = {1'b0, a_chh_reg[31:0], 32'd0} + {1'b0, a_chl_reg};
    assign chclip  = (a_chh_reg[47:32] != 16'd0) || chsum[64];
    assign ch      = chclip ? '1 : chsum[63:0];

    // Stage C: scaled step numerator.
    assign num = {32'd0, b_mh_reg} * {32'd0, cfg.step_size};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_side_reg       <= in_side;
            a_mneg_reg       <= in_m[31];
            a_mp_reg         <= mp;
            a_chh_reg        <= chh;
            a_chl_reg        <= chl;
            b_side_reg       <= a_side_reg;
            b_mneg_reg       <= a_mneg_reg;
            b_mh_reg         <= mh;
            b_ch_reg         <= ch;
            b_sat_reg        <= mclip || chclip;
            c_carry_reg.side <= b_side_reg;
            c_carry_reg.mneg <= b_mneg_reg;
            c_carry_reg.sat  <= b_sat_reg;
            c_carry_reg.num  <= num;
            c_ch_reg         <= b_ch_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_carry = c_carry_reg;
    assign out_ch    = c_ch_reg;

endmodule

### rtl/core/apu_sqrt.sv
// Pipelined integer square root, two result bits per stage.
`timescale 1ns / 1ps

module apu_sqrt import apu_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  apu_carry_t  in_carry,
    input  logic [63:0] in_ch,
    output logic        out_valid,
    output apu_carry_t  out_carry,
    output logic [31:0] out_root
);

    typedef struct packed {
        logic [63:0] v;
        logic [35:0] rem;
        logic [31:0] root;
    } sqrt_st_t;

    logic       valid_reg [SQRT_STAGES];
    apu_carry_t carry_reg [SQRT_STAGES];
    sqrt_st_t   st_reg    [SQRT_STAGES];
    sqrt_st_t   st_next   [SQRT_STAGES];

    // Each stage brings down two bit pairs of the radicand.
    always_comb
    begin
        sqrt_st_t    cur;
        logic [35:0] trial;
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            if (k == 0)
            begin
                cur.v    = in_ch;
                cur.rem  = '0;
                cur.root = '0;
            end
            else
            begin
                cur = st_reg[k-1];
            end
            for (int s = 0; s < SQRT_STEPS; s++)
            begin
                cur.rem = {cur.rem[33:0], cur.v[63:62]};
                trial   = {2'b00, cur.root, 2'b01};
                if (cur.rem >= trial)
                begin
                    cur.rem  = cur.rem - trial;
                    cur.root = {cur.root[30:0], 1'b1};
                end
                else
                begin
                    cur.root = {cur.root[30:0], 1'b0};
                end
                cur.v = {cur.v[61:0], 2'b00};
            end
            st_next[k] = cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SQRT_STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < SQRT_STAGES; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            carry_reg[0] <= in_carry;
            for (int k = 1; k < SQRT_STAGES; k++)
            begin
                carry_reg[k] <= carry_reg[k-1];
            end
            for (int k = 0; k < SQRT_STAGES; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid = valid_reg[SQRT_STAGES-1];
    assign out_carry = carry_reg[SQRT_STAGES-1];
    assign out_root  = st_reg[SQRT_STAGES-1].root;

endmodule

### rtl/core/apu_div.sv
// Denominator, pipelined divider and the final weight update with saturation.
`timescale 1ns / 1ps

module apu_div import apu_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  apu_cfg_t                 cfg,
    input  logic                     in_valid,
    input  apu_carry_t               in_carry,
    input  logic [31:0]              in_root,
    output logic                     out_valid,
    output logic [IDX_W-1:0]         out_idx,
    output logic signed [DATA_W-1:0] out_weight,
    output logic                     out_sat
);

    typedef struct packed {
        logic [63:0] n;
        logic [33:0] rem;
    } div_st_t;

    logic [32:0]              dsum, den;
    logic                     d_valid_reg;
    apu_carry_t               d_carry_reg;
    logic [32:0]              d_den_reg;

    logic                     valid_reg [DIV_STAGES];
    apu_carry_t               carry_reg [DIV_STAGES];
    logic [32:0]              den_reg   [DIV_STAGES];
    div_st_t                  st_reg    [DIV_STAGES];
    div_st_t                  st_next   [DIV_STAGES];

    logic [63:0]              qround;
    logic [31:0]              delta;
    logic signed [33:0]       wext, dext, nw;
    logic                     nw_hi, nw_lo;
    logic signed [DATA_W-1:0] nw_sat;

    logic                     o_valid_reg;
    logic [IDX_W-1:0]         o_idx_reg;
    logic signed [DATA_W-1:0] o_weight_reg;
    logic                     o_sat_reg;

    // Denominator: root plus epsilon, never zero.
    assign dsum = {1'b0, in_root} + {2'b00, cfg.epsilon};
    assign den  = (dsum == '0) ? 33'd1 : dsum;

    // Restoring division, two quotient bits per stage; quotient shifts into n.
    always_comb
    begin
        div_st_t     cur;
        logic [32:0] dv;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                cur.n   = d_carry_reg.num;
                cur.rem = '0;
                dv      = d_den_reg;
            end
            else
            begin
                cur = st_reg[k-1];
                dv  = den_reg[k-1];
            end
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                cur.rem = {cur.rem[32:0], cur.n[63]};
                if (cur.rem >= {1'b0, dv})
                begin
                    cur.rem = cur.rem - {1'b0, dv};
                    cur.n   = {cur.n[62:0], 1'b1};
                end
                else
                begin
                    cur.n = {cur.n[62:0], 1'b0};
                end
            end
            st_next[k] = cur;
        end
    end

    // Round the quotient to Q8.24 and apply it to the weight.
    assign qround = st_reg[DIV_STAGES-1].n + 64'd2147483648;
    assign delta  = qround[63:32];
    assign wext   = 34'(carry_reg[DIV_STAGES-1].side.weight);
    assign dext   = $signed({2'b00, delta});
    assign nw     = carry_reg[DIV_STAGES-1].mneg ? (wext + dext) : (wext - dext);
    assign nw_hi  = nw > Q824_MAX;
    assign nw_lo  = nw < Q824_MIN;
    assign nw_sat = nw_hi ? DATA_W'(Q824_MAX) : (nw_lo ? DATA_W'(Q824_MIN) : DATA_W'(nw));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            d_valid_reg  <= in_valid;
            valid_reg[0] <= d_valid_reg;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
            o_valid_reg <= valid_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_carry_reg  <= in_carry;
            d_den_reg    <= den;
            carry_reg[0] <= d_carry_reg;
            den_reg[0]   <= d_den_reg;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                carry_reg[k] <= carry_reg[k-1];
                den_reg[k]   <= den_reg[k-1];
            end
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                st_reg[k] <= st_next[k];
            end
            o_idx_reg    <= carry_reg[DIV_STAGES-1].side.idx;
            o_weight_reg <= nw_sat;
            o_sat_reg    <= carry_reg[DIV_STAGES-1].sat || nw_hi || nw_lo;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_idx    = o_idx_reg;
    assign out_weight = o_weight_reg;
    assign out_sat    = o_sat_reg;

endmodule

### rtl/core/adam_parameter_update.sv
// Adam parameter update: streams weight and gradient words, returns updated weights.
//
// Channels: "item" takes one word per handshake (param_index, weight, gradient);
// "result" returns one word per item (param_index_out, new_weight, saturated),
// in the same order. Registers are written through wr_en, wr_index and wr_data;
// the user must write them only while no word is in flight, which the block
// itself does not enforce. An index past the last register is ignored.
// Throughput: one word per cycle while the receiver does not stall and no slot
// hazard holds. A word passes the 5-stage moment update, 3 correction stages,
// the 16-stage square root and the 34 divider and output stages.
// A word whose slot is held by a word still in moment stages 1 to 4 is held off
// until the earlier update is written; the moment store read-modify-write loop
// sets this. Reset: registers take their defaults and both moment stores are
// zeroed by a clearing pass over all 4096 slots, during which no word is accepted.
// When the receiver stalls, the whole pipeline holds and nothing is lost.
`timescale 1ns / 1ps

module adam_parameter_update import apu_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [31:0] wr_data,
    apu_in_if.sink      item,
    apu_out_if.source   result
);

`include "adam_parameter_update_assert.svh"

    apu_cfg_t                 cfg_reg, cfg_next;
    logic                     adv, acc, clear_done, hazard;
    logic                     mo_valid, sc_valid, sq_valid, dv_valid;
    apu_side_t                mo_side;
    logic signed [DATA_W-1:0] mo_m;
    logic [CACHE_W-1:0]       mo_c;
    apu_carry_t               sc_carry, sq_carry;
    logic [63:0]              sc_ch;
    logic [31:0]              sq_root;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (apu_reg_t'(wr_index))
                REG_STEP_SIZE:  cfg_next.step_size           = wr_data;
                REG_BETA_ONE:   cfg_next.beta_one            = wr_data;
                REG_BETA_TWO:   cfg_next.beta_two            = wr_data;
                REG_MOM_CORR:   cfg_next.momentum_correction = wr_data;
                REG_CACHE_CORR: cfg_next.cache_correction    = wr_data;
                REG_EPSILON:    cfg_next.epsilon             = wr_data[EPS_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size           <= STEP_SIZE_RST;
            cfg_reg.beta_one            <= BETA_ONE_RST;
            cfg_reg.beta_two            <= BETA_TWO_RST;
            cfg_reg.momentum_correction <= MOM_CORR_RST;
            cfg_reg.cache_correction    <= CACHE_CORR_RST;
            cfg_reg.epsilon             <= EPSILON_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The pipeline moves whenever the output register is free or being taken.
    assign adv        = !dv_valid || result.ready;
    assign item.ready = adv && clear_done && !hazard;
    assign acc        = item.valid && item.ready;

    apu_moment u_moment (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .cfg          (cfg_reg),
        .acc          (acc),
        .acc_idx      (item.param_index),
        .acc_weight   (item.weight),
        .acc_gradient (item.gradient),
        .clear_done   (clear_done),
        .hazard       (hazard),
        .out_valid    (mo_valid),
        .out_side     (mo_side),
        .out_m        (mo_m),
        .out_c        (mo_c)
    );

    apu_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg_reg),
        .in_valid  (mo_valid),
        .in_side   (mo_side),
        .in_m      (mo_m),
        .in_c      (mo_c),
        .out_valid (sc_valid),
        .out_carry (sc_carry),
        .out_ch    (sc_ch)
    );

    apu_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sc_valid),
        .in_carry  (sc_carry),
        .in_ch     (sc_ch),
        .out_valid (sq_valid),
        .out_carry (sq_carry),
        .out_root  (sq_root)
    );

    apu_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .cfg        (cfg_reg),
        .in_valid   (sq_valid),
        .in_carry   (sq_carry),
        .in_root    (sq_root),
        .out_valid  (dv_valid),
        .out_idx    (result.param_index_out),
        .out_weight (result.new_weight),
        .out_sat    (result.saturated)
    );

    assign result.valid = dv_valid;

    // No word enters before the stores are cleared or while its slot is busy.
    `APU_ASSERT_NOW(a_no_acc_in_clear, acc, clear_done, "word accepted during clearing pass")
    `APU_ASSERT_NOW(a_no_acc_on_hazard, acc, !hazard, "word accepted while slot in flight")
    `APU_ASSERT_NEXT(a_clear_stays, clear_done, clear_done, "clearing pass restarted")

endmodule
